@@ hdl/three_axis_biquad_lowpass_assert.svh @@
// Assertion macros for the three-axis biquad low-pass filter.
// Included by the top level; needs i_clk and i_rst_n in the including scope.
`ifndef THREE_AXIS_BIQUAD_LOWPASS_ASSERT_SVH
`define THREE_AXIS_BIQUAD_LOWPASS_ASSERT_SVH
`ifndef SYNTHESIS
`define TABLP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tablp: same-cycle check failed");
`define TABLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tablp: next-cycle check failed");
`else
`define TABLP_ASSERT_SAME(label, ante, cons)
`define TABLP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/tablp_pkg.sv @@
// Shared types, codes and constants of the three-axis biquad low-pass filter.
// No dependencies.
`default_nettype none

package tablp_pkg;

    localparam int LANES              = 3;
    localparam int DEF_SAMPLE_WIDTH   = 16;
    localparam int DEF_COEF_WIDTH     = 24;
    localparam int ACC_MAX_WIDTH      = 64;
    localparam int CFG_INDEX_WIDTH    = 3;

    typedef enum logic [1:0] {
        REQ_ALL   = 2'd0,
        REQ_LANE0 = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        LOP_NONE,
        LOP_FILT,
        LOP_CLEAR
    } t_lane_op;

    typedef struct packed {
        logic     adv;
        t_lane_op op_in;
        t_lane_op op_s3;
    } t_lane_ctl;

    function automatic t_lane_op f_lane_op(input t_req req, input logic is_lane0);
        t_lane_op op;
        case (req)
            REQ_ALL:   op = LOP_FILT;
            REQ_LANE0: op = is_lane0 ? LOP_FILT : LOP_NONE;
            REQ_CLEAR: op = LOP_CLEAR;
            REQ_NONE:  op = LOP_NONE;
            default:   op = LOP_NONE;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

@@ hdl/tablp_lane.sv @@
// One filter lane: feedforward products, partial sum with the older feedback
// term, then the feedback stage with round and saturate. Uses tablp_pkg.
`default_nettype none

module tablp_lane import tablp_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_lane_ctl                      i_ctl,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic signed [COEF_WIDTH-1:0]   i_coef_b0,
    input  wire logic signed [COEF_WIDTH-1:0]   i_coef_b1,
    input  wire logic signed [COEF_WIDTH-1:0]   i_coef_b2,
    input  wire logic signed [COEF_WIDTH-1:0]   i_coef_a1,
    input  wire logic signed [COEF_WIDTH-1:0]   i_coef_a2,
    output logic signed [SAMPLE_WIDTH-1:0]      o_y,
    output logic                                o_clip
);

    localparam int PW     = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = (PW + 3 > ACC_MAX_WIDTH) ? ACC_MAX_WIDTH : PW + 3;
    localparam int FRAC   = COEF_WIDTH - 2;
    localparam int TOP_LO = FRAC + SAMPLE_WIDTH - 1;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (FRAC - 1);
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // history
    logic signed [SAMPLE_WIDTH-1:0] r_xd1, r_xd2, r_yd1, r_yd2;
    // stage 1 products
    logic signed [PW-1:0]           r_p0, r_p1, r_p2;
    // stage 2
    logic signed [ACC_W-1:0]        r_ff;
    logic signed [PW-1:0]           r_fb2;

    logic signed [SAMPLE_WIDTH-1:0] w_y2;
    logic signed [PW-1:0]           w_fb1;
    logic signed [ACC_W-1:0]        w_acc;
    logic [ACC_W-1-TOP_LO:0]        w_hi_bits;

    // Input history moves when an accepted beat filters or clears this lane.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xd1 <= '0;
            r_xd2 <= '0;
        end else if (i_ctl.adv) begin
            case (i_ctl.op_in)
                LOP_FILT: begin
                    r_xd2 <= r_xd1;
                    r_xd1 <= i_sample;
                end
                LOP_CLEAR: begin
                    r_xd1 <= '0;
                    r_xd2 <= '0;
                end
                default: ;
            endcase
        end
    end

    // Two steps back as seen by the beat in stage 2: the beat in stage 3
    // has not yet written its output into the history.
    always_comb begin
        case (i_ctl.op_s3)
            LOP_FILT:  w_y2 = r_yd1;
            LOP_CLEAR: w_y2 = '0;
            default:   w_y2 = r_yd2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_p0  <= i_coef_b0 * i_sample;
            r_p1  <= i_coef_b1 * r_xd1;
            r_p2  <= i_coef_b2 * r_xd2;
            r_ff  <= ACC_W'(r_p0) + ACC_W'(r_p1) + ACC_W'(r_p2);
            r_fb2 <= i_coef_a2 * w_y2;
        end
    end

    assign w_fb1     = i_coef_a1 * r_yd1;
    assign w_acc     = r_ff - ACC_W'(r_fb2) - ACC_W'(w_fb1) + RND;
    assign w_hi_bits = w_acc[ACC_W-1:TOP_LO];
    assign o_clip    = !((&w_hi_bits) || (~|w_hi_bits));
    assign o_y       = o_clip ? (w_acc[ACC_W-1] ? SAT_NEG : SAT_POS) : w_acc[TOP_LO:FRAC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yd1 <= '0;
            r_yd2 <= '0;
        end else if (i_ctl.adv) begin
            case (i_ctl.op_s3)
                LOP_FILT: begin
                    r_yd2 <= r_yd1;
                    r_yd1 <= o_y;
                end
                LOP_CLEAR: begin
                    r_yd1 <= '0;
                    r_yd2 <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/three_axis_biquad_lowpass.sv @@
// Top level of the three-axis biquad low-pass filter: coefficient registers,
// pipeline control, lanes and the merging output register. Uses tablp_pkg, tablp_lane.
`default_nettype none
`include "three_axis_biquad_lowpass_assert.svh"

// Three-lane direct form I biquad, one beat per clock cycle sustained while not
// stalled; an accepted beat passes the product, sum and output registers. The
// rate is set by the feedback stage of each lane, where the product of a1 with
// the last output, the add, rounding and saturation are combinational. A full
// output register under stall holds the whole pipeline and stalls the input.
// Coefficients reset to zero and are written through the config port, which is
// always ready; indexes beyond the five coefficients are dropped.
module three_axis_biquad_lowpass import tablp_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample_z,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      o_filtered_x,
    output logic signed [SAMPLE_WIDTH-1:0]      o_filtered_y,
    output logic signed [SAMPLE_WIDTH-1:0]      o_filtered_z,
    output logic                                o_saturated,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]     i_cfg_index,
    input  wire logic [COEF_WIDTH-1:0]          i_cfg_data
);

    logic signed [COEF_WIDTH-1:0]   r_coef_b0, r_coef_b1, r_coef_b2, r_coef_a1, r_coef_a2;
    logic                           r_v1, r_v2, r_out_valid;
    t_req                           r_req1, r_req2;
    logic signed [SAMPLE_WIDTH-1:0] r_out_y [LANES];
    logic                           r_out_sat;

    logic                           w_adv, w_accept;
    t_lane_ctl                      w_ctl    [LANES];
    logic signed [SAMPLE_WIDTH-1:0] w_sample [LANES];
    logic signed [SAMPLE_WIDTH-1:0] w_y      [LANES];
    logic [LANES-1:0]               w_clip;
    logic [LANES-1:0]               w_filt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b0 <= '0;
            r_coef_b1 <= '0;
            r_coef_b2 <= '0;
            r_coef_a1 <= '0;
            r_coef_a2 <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_B0:  r_coef_b0 <= i_cfg_data;
                REG_B1:  r_coef_b1 <= i_cfg_data;
                REG_B2:  r_coef_b2 <= i_cfg_data;
                REG_A1:  r_coef_a1 <= i_cfg_data;
                REG_A2:  r_coef_a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold everything while a finished beat waits downstream.
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_adv;
    assign w_accept   = i_in_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v1        <= w_accept;
            r_v2        <= r_v1;
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_req1 <= t_req'(i_req_type);
            r_req2 <= r_req1;
        end
    end

    assign w_sample[0] = i_sample_x;
    assign w_sample[1] = i_sample_y;
    assign w_sample[2] = i_sample_z;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_ctl[l].adv   = w_adv;
            w_ctl[l].op_in = w_accept ? f_lane_op(t_req'(i_req_type), l == 0) : LOP_NONE;
            w_ctl[l].op_s3 = r_v2 ? f_lane_op(r_req2, l == 0) : LOP_NONE;
            w_filt[l]      = (w_ctl[l].op_s3 == LOP_FILT);
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        tablp_lane #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .COEF_WIDTH   (COEF_WIDTH)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl[l]),
            .i_sample  (w_sample[l]),
            .i_coef_b0 (r_coef_b0),
            .i_coef_b1 (r_coef_b1),
            .i_coef_b2 (r_coef_b2),
            .i_coef_a1 (r_coef_a1),
            .i_coef_a2 (r_coef_a2),
            .o_y       (w_y[l]),
            .o_clip    (w_clip[l])
        );
    end

    // Merge: zero the lanes that did not filter, and flag any clipped lane that filtered.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int l = 0; l < LANES; l++) begin
                r_out_y[l] <= w_filt[l] ? w_y[l] : '0;
            end
            r_out_sat <= |(w_clip & w_filt);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_filtered_x = r_out_y[0];
    assign o_filtered_y = r_out_y[1];
    assign o_filtered_z = r_out_y[2];
    assign o_saturated  = r_out_sat;

    `TABLP_ASSERT_NEXT(a_accept_enters, (i_in_valid && !o_in_stall), r_v1)
    `TABLP_ASSERT_NEXT(a_clear_zero, (r_v2 && r_req2 == REQ_CLEAR && w_adv),
        (o_out_valid && o_filtered_x == '0 && o_filtered_y == '0 && o_filtered_z == '0 && !o_saturated))
    `TABLP_ASSERT_NEXT(a_lane0_only, (r_v2 && r_req2 == REQ_LANE0 && w_adv),
        (o_filtered_y == '0 && o_filtered_z == '0))
    `TABLP_ASSERT_SAME(a_sat_at_limit, (o_out_valid && o_saturated),
        (o_filtered_x == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} || o_filtered_x == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} ||
         o_filtered_y == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} || o_filtered_y == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} ||
         o_filtered_z == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} || o_filtered_z == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}))

endmodule

`default_nettype wire
